FILE: sv/wildcard_glob_matcher_core_defines.svh
// Assertion macros for the wildcard glob matcher checker.
// Depends on nothing; the including module provides clk and rst.
`ifndef WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WGM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wildcard glob matcher: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wildcard glob matcher: next-cycle check failed");

`endif

FILE: sv/wgm_pkg.sv
// Shared constants, types and helper functions for the wildcard glob matcher.
// Depends on nothing; used by the cell, the closure unit and the top level.
`timescale 1ns / 1ps

package wgm_pkg;

  // Pattern geometry.
  localparam int PATTERN_LEN   = 48;
  localparam int POS_W         = PATTERN_LEN + 1;
  localparam int LEN_W         = 6;
  localparam int NUM_CHAR_REGS = 6;
  localparam int CHARS_PER_REG = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 4;

  // Special pattern bytes.
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_QUEST = 8'h3F;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 4'd1;
  localparam int                   REG_CHARS_BASE     = 2;

  // Control shared by every cell of the row.
  typedef struct packed {
    logic       fresh;     // live set is the start set
    logic       load;      // take the stepped live bit
    logic       case_sens; // compare bytes exactly
    logic [7:0] text_c;    // folded text byte
  } wgm_row_ctrl_t;

  // What a cell shows to its neighbor and to the closure unit.
  typedef struct packed {
    logic star; // pattern byte is a star in use
    logic adv;  // live position consumes the text byte
    logic raw;  // stepped bit before star closure
  } wgm_cell_out_t;

  // Fold ASCII upper case to lower case when case sensitivity is off.
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic cs);
    logic [7:0] r;
    r = c;
    if (!cs && (c inside {[8'h41:8'h5A]})) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: sv/wgm_cell.sv
// One pattern position of the matcher row: holds its live bit and compares its byte.
// Depends on wgm_pkg.
`timescale 1ns / 1ps

module wgm_cell (
  input  logic                  clk,
  input  logic                  in_use,
  input  logic [7:0]            pat_char,
  input  logic                  start_bit,
  input  logic                  next_bit,
  input  logic                  adv_in,
  input  wgm_pkg::wgm_row_ctrl_t ctrl,
  output wgm_pkg::wgm_cell_out_t cout
);
  import wgm_pkg::*;

  logic       live;
  logic       cur;
  logic       is_star;
  logic       is_quest;
  logic       is_equal;
  logic [7:0] pat_fold;

  // Current live bit: the start set right after a restart.
  assign cur = ctrl.fresh ? start_bit : live;

  // Byte compare against the folded text byte.
  always_comb begin
    pat_fold = fold_char(pat_char, ctrl.case_sens);
    is_star  = (pat_char == CHAR_STAR);
    is_quest = (pat_char == CHAR_QUEST);
    is_equal = (pat_fold == ctrl.text_c);
  end

  // A star keeps its position alive; a match hands the token to the right.
  always_comb begin
    cout.star = in_use & is_star;
    cout.adv  = cur & in_use & ~is_star & (is_quest | is_equal);
    cout.raw  = (cur & cout.star) | adv_in;
  end

  // Live bit register, loaded when a string continues.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      live <= next_bit;
    end
  end

endmodule

FILE: sv/wgm_closure.sv
// Star closure of a position set: every run of stars is skipped with one carry add.
// Depends on wgm_pkg.
`timescale 1ns / 1ps

module wgm_closure (
  input  logic [wgm_pkg::POS_W-1:0]       seed,
  input  logic [wgm_pkg::PATTERN_LEN-1:0] star_mask,
  output logic [wgm_pkg::POS_W-1:0]       closed
);
  import wgm_pkg::*;

  logic [POS_W-1:0] stars;
  logic [POS_W-1:0] sum;

  // A seed inside a run of stars carries through the run to the first
  // non-star position; the flipped bits are exactly the reached positions.
  always_comb begin
    stars  = {1'b0, star_mask};
    sum    = stars + (seed & stars);
    closed = seed | (sum ^ stars);
  end

endmodule

FILE: sv/wildcard_glob_matcher_core.sv
// The match bit is registered; under a held output it waits in the spare result register.
// Throughput: one text byte per cycle, back to back while in_ready is high; the row
// update (compare per cell, one 49-bit carry add for star closure) is combinational.
// A spare result register keeps input open while one result waits; two waiting stall it.
// Reset: configuration returns to case sensitive, empty pattern; the live set is the
// start set and no result is pending.
`timescale 1ns / 1ps

module wildcard_glob_matcher_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [wgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wgm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     text_char,
  input  logic                           empty_text,
  input  logic                           last_char,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           matched
);
  import wgm_pkg::*;

  logic                                  case_sensitive;
  logic [LEN_W-1:0]                      pattern_length;
  logic [NUM_CHAR_REGS-1:0][CFG_DATA_W-1:0] pattern_chars;
  logic                                  fresh;
  logic                                  cfg_hit;
  logic [LEN_W-1:0]                      used_len;
  logic                                  in_fire;
  logic                                  ends_string;
  wgm_row_ctrl_t                         ctrl;
  wgm_cell_out_t [PATTERN_LEN-1:0]       couts;
  logic [PATTERN_LEN-1:0]                star_mask;
  logic [POS_W-1:0]                      raw_set;
  logic [POS_W-1:0]                      start_set;
  logic [POS_W-1:0]                      step_set;
  logic                                  matched_next;
  logic                                  skid_valid;
  logic                                  skid_matched;
  logic                                  res_push;
  logic                                  out_free;

  // Handshake and request decode.
  assign in_ready    = ~skid_valid;
  assign in_fire     = in_valid & in_ready;
  assign ends_string = empty_text | last_char;
  assign res_push    = in_fire & ends_string;
  assign out_free    = ~out_valid | out_ready;

  // Lengths above the row size use the whole row.
  assign used_len = (pattern_length > LEN_W'(PATTERN_LEN)) ? LEN_W'(PATTERN_LEN)
                                                           : pattern_length;

  // Only writes to listed registers restart the string.
  assign cfg_hit = cfg_wr_en &
                   (cfg_index < CFG_IDX_W'(REG_CHARS_BASE + NUM_CHAR_REGS));

  // Row control.
  always_comb begin
    ctrl.fresh     = fresh;
    ctrl.load      = in_fire & ~ends_string;
    ctrl.case_sens = case_sensitive;
    ctrl.text_c    = fold_char(text_char, case_sensitive);
  end

  // Row of position cells; each hands its advance to the next one.
  for (genvar i = 0; i < PATTERN_LEN; i++) begin : g_cell
    wgm_cell u_cell (
      .clk       (clk),
      .in_use    (LEN_W'(i) < used_len),
      .pat_char  (pattern_chars[i / CHARS_PER_REG][(i % CHARS_PER_REG) * 8 +: 8]),
      .start_bit (start_set[i]),
      .next_bit  (step_set[i]),
      .adv_in    ((i == 0) ? 1'b0 : couts[(i == 0) ? 0 : i - 1].adv),
      .ctrl      (ctrl),
      .cout      (couts[i])
    );
    assign star_mask[i] = couts[i].star;
    assign raw_set[i]   = couts[i].raw;
  end
  assign raw_set[PATTERN_LEN] = couts[PATTERN_LEN-1].adv;

  // Star closure of the start position and of the stepped set.
  wgm_closure u_start_closure (
    .seed      (POS_W'(1)),
    .star_mask (star_mask),
    .closed    (start_set)
  );

  wgm_closure u_step_closure (
    .seed      (raw_set),
    .star_mask (star_mask),
    .closed    (step_set)
  );

  // Match bit: the accepting position is live.
  assign matched_next = empty_text ? start_set[used_len] : step_set[used_len];

  // Configuration registers, restart flag and result valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      case_sensitive <= 1'b1;
      pattern_length <= '0;
      pattern_chars  <= '0;
      fresh          <= 1'b1;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CASE_SENSITIVE: case_sensitive <= cfg_wdata[0];
          REG_PATTERN_LENGTH: pattern_length <= cfg_wdata[LEN_W-1:0];
          default: begin
            for (int k = 0; k < NUM_CHAR_REGS; k++) begin
              if (cfg_index == CFG_IDX_W'(REG_CHARS_BASE + k)) begin
                pattern_chars[k] <= cfg_wdata;
              end
            end
          end
        endcase
      end
      if (cfg_hit) begin
        fresh <= 1'b1;
      end else if (in_fire) begin
        fresh <= ends_string;
      end
      // The spare slot drains into the output slot as soon as that one frees up.
      if (out_free) begin
        out_valid  <= skid_valid | res_push;
        skid_valid <= 1'b0;
      end else if (res_push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        matched <= skid_matched;
      end else if (res_push) begin
        matched <= matched_next;
      end
    end else if (res_push) begin
      skid_matched <= matched_next;
    end
  end

endmodule

FILE: sv/wgm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to the top level.
// Depends on wildcard_glob_matcher_core_defines.svh.
`timescale 1ns / 1ps
`include "wildcard_glob_matcher_core_defines.svh"

module wgm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic empty_text,
  input logic last_char,
  input logic out_valid,
  input logic out_ready,
  input logic matched
);

  // A stalled result stays offered with the same value.
  `WGM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `WGM_ASSERT_NEXT(a_matched_hold, out_valid && !out_ready, $stable(matched))

  // With no result pending the block takes a new request.
  `WGM_ASSERT_SAME(a_ready_when_free, !out_valid, in_ready)

  // A string end always leaves some result offered in the next cycle.
  `WGM_ASSERT_NEXT(a_end_gives_result,
                   in_valid && in_ready && (empty_text || last_char), out_valid)

  // A new result only follows a string end.
  `WGM_ASSERT_SAME(a_result_has_cause, $rose(out_valid),
                   $past(in_valid && in_ready && (empty_text || last_char)))

endmodule

bind wildcard_glob_matcher_core wgm_checker u_wgm_checker (.*);

FILE: dv/wildcard_glob_matcher_core_checker.sv
// Checker for the wildcard glob matcher: watches the config, request and result
// channels, predicts every match bit, and compares it with what the block returns.
// Depends on wgm_pkg for widths, register indexes and the special pattern bytes.
`timescale 1ns / 1ps

module wildcard_glob_matcher_core_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [wgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wgm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     text_char,
  input  logic                           empty_text,
  input  logic                           last_char,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           matched,
  output int                             mismatch_count,
  output int                             match_backlog,
  output int                             results_seen,
  output int                             requests_seen
);
  import wgm_pkg::*;

  // Shadow copy of the configuration and of the live position set.
  logic                  case_mode;
  logic [LEN_W-1:0]      len_reg;
  logic [CFG_DATA_W-1:0] char_regs [NUM_CHAR_REGS];
  logic [POS_W-1:0]      alive;
  bit                    match_forecast [$];
  logic                  forecast_bit;
  logic                  reg_known;

  // ASCII letters fold to lower case only when case sensitivity is off.
  function automatic logic [7:0] casefold_byte(logic [7:0] c, logic exact);
    if (!exact && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // Pattern lengths above the row size are clamped to the row size.
  function automatic int active_len();
    return (len_reg > PATTERN_LEN) ? PATTERN_LEN : int'(len_reg);
  endfunction

  function automatic logic [7:0] pattern_byte(int i);
    logic [CFG_DATA_W-1:0] word;
    word = char_regs[i / CHARS_PER_REG];
    return casefold_byte(word[(i % CHARS_PER_REG) * 8 +: 8], case_mode);
  endfunction

  // A live position sitting on a star also makes the next position live.
  function automatic logic [POS_W-1:0] star_fill(logic [POS_W-1:0] s);
    logic [POS_W-1:0] r;
    int               n;
    r = s;
    n = active_len();
    for (int i = 0; i < n; i++) begin
      if (r[i] && pattern_byte(i) == CHAR_STAR) r[i+1] = 1'b1;
    end
    return r;
  endfunction

  // One text byte: stars hold their position, '?' and equal bytes move on.
  function automatic logic [POS_W-1:0] advance_live(logic [POS_W-1:0] s, logic [7:0] c);
    logic [POS_W-1:0] nxt;
    logic [7:0]       p;
    int               n;
    nxt = '0;
    n   = active_len();
    for (int i = 0; i < n; i++) begin
      if (s[i]) begin
        p = pattern_byte(i);
        if (p == CHAR_STAR) nxt[i] = 1'b1;
        else if (p == CHAR_QUEST || p == c) nxt[i+1] = 1'b1;
      end
    end
    return star_fill(nxt);
  endfunction

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] checker: %s", $realtime, msg);
  endtask

  // Model update and comparison, all sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      case_mode = 1'b1;
      len_reg   = '0;
      foreach (char_regs[k]) char_regs[k] = '0;
      alive = star_fill(POS_W'(1));
      match_forecast.delete();
      mismatch_count = 0;
      results_seen   = 0;
      requests_seen  = 0;
    end else begin
      // A returned result always belongs to an earlier request.
      if (out_valid && out_ready) begin
        results_seen++;
        if (match_forecast.size() == 0) begin
          note_failure($sformatf("result %0d arrived with none expected, matched=%0b",
                                 results_seen, matched));
        end else begin
          forecast_bit = match_forecast.pop_front();
          if (matched !== forecast_bit) begin
            note_failure($sformatf("result %0d: expected matched=%0b, got %0b",
                                   results_seen, forecast_bit, matched));
          end
        end
      end

      // Any known register write restarts the live set.
      if (cfg_wr_en) begin
        reg_known = 1'b1;
        if (cfg_index == REG_CASE_SENSITIVE) begin
          case_mode = cfg_wdata[0];
        end else if (cfg_index == REG_PATTERN_LENGTH) begin
          len_reg = cfg_wdata[LEN_W-1:0];
        end else if (int'(cfg_index) >= REG_CHARS_BASE &&
                     int'(cfg_index) < REG_CHARS_BASE + NUM_CHAR_REGS) begin
          char_regs[int'(cfg_index) - REG_CHARS_BASE] = cfg_wdata;
        end else begin
          reg_known = 1'b0;
        end
        if (reg_known) alive = star_fill(POS_W'(1));
      end

      // Text request: an empty item wins over the byte and the last mark.
      if (in_valid && in_ready) begin
        requests_seen++;
        if (empty_text) begin
          alive = star_fill(POS_W'(1));
          match_forecast.insert(match_forecast.size(), alive[active_len()]);
        end else begin
          alive = advance_live(alive, casefold_byte(text_char, case_mode));
          if (last_char) begin
            match_forecast.insert(match_forecast.size(), alive[active_len()]);
            alive = star_fill(POS_W'(1));
          end
        end
      end
    end
    match_backlog = match_forecast.size();
  end

endmodule

FILE: dv/testbench.sv
// Top of the glob matcher testbench: clock, reset, pattern setup and text requests,
// random stalls on both channels, and the final verdict from the checker's count.
// Depends on wgm_pkg, wildcard_glob_matcher_core and wildcard_glob_matcher_core_checker.
`timescale 1ns / 1ps

module testbench;
  import wgm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;
  localparam int RANDOM_REQUESTS = 600;

  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [7:0]            text_char  = '0;
  logic                  empty_text = 1'b0;
  logic                  last_char  = 1'b0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic                  matched;

  int mismatch_count;
  int match_backlog;
  int results_seen;
  int requests_seen;

  bit         idle_enable = 1'b1;
  int         phase_count = 0;
  logic [7:0] pat_mem [PATTERN_LEN];
  logic [7:0] text_bytes [$];

  wildcard_glob_matcher_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_char  (text_char),
    .empty_text (empty_text),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .matched    (matched)
  );

  wildcard_glob_matcher_core_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .text_char      (text_char),
    .empty_text     (empty_text),
    .last_char      (last_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .matched        (matched),
    .mismatch_count (mismatch_count),
    .match_backlog  (match_backlog),
    .results_seen   (results_seen),
    .requests_seen  (requests_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side stalls at random except during the quiet phases.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !idle_enable || ($urandom_range(99) >= 20);
  end

  initial begin
    #3_000_000;
    $display("wildcard_glob_matcher_core verification failed");
    $finish;
  end

  // Small alphabet so that literals, wildcards and case folding collide often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h41;
      3:       return 8'h42;
      4:       return CHAR_STAR;
      5:       return CHAR_QUEST;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One text request, held until the block takes it.
  task automatic push_request(logic [7:0] ch, logic empty, logic last);
    if (idle_enable) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    text_char  <= ch;
    empty_text <= empty;
    last_char  <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Hold off until every predicted result has been returned, then let the block settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (match_backlog != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Write every register: case and length from the arguments, bytes from the pattern buffer.
  task automatic load_pattern(logic exact, logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] word;
    write_reg(REG_CASE_SENSITIVE, CFG_DATA_W'(exact));
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    for (int k = 0; k < NUM_CHAR_REGS; k++) begin
      for (int j = 0; j < CHARS_PER_REG; j++) word[j*8 +: 8] = pat_mem[k*CHARS_PER_REG + j];
      write_reg(CFG_IDX_W'(REG_CHARS_BASE + k), word);
    end
    end_writes();
    phase_count++;
  endtask

  // Unused pattern bytes get random filler.
  task automatic set_pattern_text(string s);
    for (int i = 0; i < PATTERN_LEN; i++) begin
      pat_mem[i] = (i < s.len()) ? s[i] : 8'($urandom_range(255));
    end
  endtask

  task automatic load_text(string s);
    text_bytes.delete();
    for (int i = 0; i < s.len(); i++) text_bytes.insert(text_bytes.size(), s[i]);
  endtask

  // Build a text that the pattern accepts, with random content under the wildcards.
  task automatic make_text(int n, logic exact);
    logic [7:0] p;
    text_bytes.delete();
    for (int i = 0; i < n; i++) begin
      p = pat_mem[i];
      if (p == CHAR_STAR) begin
        repeat ($urandom_range(2)) text_bytes.insert(text_bytes.size(), pick_byte());
      end else if (p == CHAR_QUEST) begin
        text_bytes.insert(text_bytes.size(), 8'($urandom_range(255)));
      end else if (!exact && ((p >= 8'h41 && p <= 8'h5A) || (p >= 8'h61 && p <= 8'h7A))
                   && $urandom_range(1)) begin
        text_bytes.insert(text_bytes.size(), p ^ 8'h20);
      end else begin
        text_bytes.insert(text_bytes.size(), p);
      end
    end
  endtask

  task automatic corrupt_text();
    int pos;
    if (text_bytes.size() == 0) begin
      text_bytes.insert(0, pick_byte());
      return;
    end
    pos = $urandom_range(text_bytes.size() - 1);
    case ($urandom_range(2))
      0:       text_bytes[pos] = pick_byte();
      1:       text_bytes.delete(pos);
      default: text_bytes.insert(pos, pick_byte());
    endcase
  endtask

  // Send the buffered text; a finished text with no bytes goes as an empty item.
  task automatic send_text(bit finish);
    if (text_bytes.size() == 0) begin
      if (finish) push_request(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
    end else begin
      foreach (text_bytes[i]) begin
        push_request(text_bytes[i], 1'b0, finish && (i == text_bytes.size() - 1));
      end
    end
  endtask

  // One random string, mostly built to get deep into the pattern.
  task automatic run_random_string(int used, logic exact, logic [LEN_W-1:0] len);
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) begin
      make_text(used, exact);
      if ($urandom_range(99) < 30) corrupt_text();
      send_text(1'b1);
    end else if (kind < 72) begin
      text_bytes.delete();
      repeat ($urandom_range(8)) text_bytes.insert(text_bytes.size(), pick_byte());
      send_text(1'b1);
    end else if (kind < 80) begin
      text_bytes.delete();
      repeat ($urandom_range(1, 6)) begin
        text_bytes.insert(text_bytes.size(), 8'($urandom_range(255)));
      end
      send_text(1'b1);
    end else if (kind < 88) begin
      push_request(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
    end else if (kind < 95) begin
      // A string cut short by an empty item.
      make_text(used, exact);
      repeat ($urandom_range(text_bytes.size())) void'(text_bytes.pop_back());
      send_text(1'b0);
      push_request(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
    end else begin
      // A string restarted by a register write in its middle.
      make_text(used, exact);
      send_text(1'b0);
      wait_for_results();
      write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
      end_writes();
      make_text(used, exact);
      send_text(1'b1);
    end
  endtask

  initial begin
    int               target;
    logic             exact;
    logic [LEN_W-1:0] len;
    int               used;
    int               pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: empty pattern accepts only the empty string.
    push_request(8'h00, 1'b1, 1'b0);
    push_request(8'hFF, 1'b0, 1'b1);

    // Literal, star and query with exact case.
    wait_for_results();
    set_pattern_text("a*b?");
    load_pattern(1'b1, LEN_W'(4));
    load_text("abx");
    send_text(1'b1);
    load_text("aBx");
    send_text(1'b1);
    // Empty item in the middle of a string.
    push_request(8'h61, 1'b0, 1'b0);
    push_request(8'h62, 1'b1, 1'b1);
    // Dead string: the first byte already kills every position.
    load_text("zabx");
    send_text(1'b1);
    // Register write in the middle of a string restarts it.
    load_text("ab");
    send_text(1'b0);
    wait_for_results();
    write_reg(REG_CASE_SENSITIVE, CFG_DATA_W'(0));
    end_writes();
    load_text("aBx");
    send_text(1'b1);

    // All stars with an oversized length, folding on.
    for (int i = 0; i < PATTERN_LEN; i++) pat_mem[i] = CHAR_STAR;
    wait_for_results();
    load_pattern(1'b0, '1);
    push_request(8'hFF, 1'b1, 1'b1);
    push_request(8'h00, 1'b0, 1'b1);
    wait_for_results();
    write_reg(REG_UNUSED, '1);
    end_writes();
    push_request(8'hFF, 1'b0, 1'b1);

    // Random phases: a fresh pattern each, then a handful of strings.
    target = requests_seen + RANDOM_REQUESTS;
    while (requests_seen < target) begin
      wait_for_results();
      idle_enable = !(phase_count >= 10 && phase_count < 15);
      exact = 1'($urandom_range(1));
      pick  = $urandom_range(99);
      if (pick < 10) len = '0;
      else if (pick < 20) len = LEN_W'(PATTERN_LEN);
      else if (pick < 27) len = LEN_W'($urandom_range(PATTERN_LEN + 1, 63));
      else len = LEN_W'($urandom_range(1, 10));
      for (int i = 0; i < PATTERN_LEN; i++) pat_mem[i] = pick_byte();
      load_pattern(exact, len);
      used = (len > PATTERN_LEN) ? PATTERN_LEN : int'(len);
      repeat ($urandom_range(3, 8)) begin
        run_random_string(used, exact, len);
        if ($urandom_range(99) < 5) wait_for_results();
      end
    end

    wait_for_results();
    repeat (5) @(posedge clk);
    $display("Summary: %0d text requests over %0d pattern setups, %0d match results checked.",
             requests_seen, phase_count, results_seen);
    $display("Summary: %0d mismatches counted.", mismatch_count);
    if (mismatch_count == 0 && match_backlog == 0) begin
      $display("wildcard_glob_matcher_core verification clean");
    end else begin
      $display("wildcard_glob_matcher_core verification failed");
    end
    $finish;
  end

endmodule

FILE: wildcard_glob_matcher_core.f
+incdir+sv
sv/wgm_pkg.sv
sv/wgm_cell.sv
sv/wgm_closure.sv
sv/wildcard_glob_matcher_core.sv
sv/wgm_checker.sv
dv/wildcard_glob_matcher_core_checker.sv
dv/testbench.sv
